// ===== src/svae_pkg.sv =====
// Shared types, constants and table functions for the sine voice.
// Used by every module of the voice; depends on nothing else.
package svae_pkg;

	localparam int SINE_ROM_BITS = 10;
	localparam int SAMPLE_BITS   = 16;
	localparam int SINE_DEPTH    = 1 << SINE_ROM_BITS;
	localparam int QUARTER       = 1 << (SINE_ROM_BITS - 2);

	localparam int OUT_BITS    = 16;
	localparam int PHASE_BITS  = 32;
	localparam int LVL_BITS    = 21;
	localparam int LVL_FRAC    = 24;
	localparam int NOTE_BITS   = 7;
	localparam int CHAN_BITS   = 5;
	localparam int VEL_BITS    = 7;
	localparam int CMD_BITS    = 2;
	localparam int FREQ_BITS   = 30;
	localparam int INC_BITS    = 28;
	localparam int INC_LO_BITS = 14;
	localparam int INC_HI_BITS = INC_BITS - INC_LO_BITS;
	localparam int STEP_BITS   = 20;
	localparam int PP_BITS     = FREQ_BITS + INC_LO_BITS;
	localparam int PS_SUM_BITS = FREQ_BITS + INC_BITS;
	localparam int PS_SHIFT    = 24;
	localparam int MUL_BITS    = LVL_BITS + 1 + SAMPLE_BITS;

	localparam int OCT_RECIP   = 43;
	localparam int OCT_SHIFT   = 9;
	localparam int OCT_PROD    = NOTE_BITS + 6;
	localparam int OCT_BITS    = 4;
	localparam int TOP_OCTAVE  = 10;
	localparam int NOTES_PER_OCT = 12;

	localparam int VEL_GAIN = 10568;
	localparam int LVL_MIN  = 167772;
	localparam int LVL_MAX  = 1342177;

	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam logic [INC_BITS-1:0]  INC_RESET     = INC_BITS'(24932236);
	localparam logic [STEP_BITS-1:0] ATTACK_RESET  = STEP_BITS'(38043);
	localparam logic [STEP_BITS-1:0] RELEASE_RESET = STEP_BITS'(9511);

	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] HALF_Q30   = 64'd536870912;
	localparam logic [63:0] SINE_AMP   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
	localparam logic [63:0] TAYLOR_D0  = 64'd156;
	localparam logic [63:0] TAYLOR_D1  = 64'd110;
	localparam logic [63:0] TAYLOR_D2  = 64'd72;
	localparam logic [63:0] TAYLOR_D3  = 64'd42;
	localparam logic [63:0] TAYLOR_D4  = 64'd20;
	localparam logic [63:0] TAYLOR_D5  = 64'd6;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		REG_INC_PER_HZ   = 2'd0,
		REG_ATTACK_STEP  = 2'd1,
		REG_RELEASE_STEP = 2'd2
	} reg_idx_e;

	typedef struct packed {
		logic [INC_BITS-1:0]  inc_per_hz;
		logic [STEP_BITS-1:0] attack_step;
		logic [STEP_BITS-1:0] release_step;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		cmd_e                 cmd;
		logic [NOTE_BITS-1:0] note;
		logic [CHAN_BITS-1:0] chan;
		logic [LVL_BITS-1:0]  tl;
		logic [PP_BITS-1:0]   p_lo;
		logic [PP_BITS-1:0]   p_hi;
	} note_cmd_t;

	typedef struct packed {
		logic                valid;
		logic                active;
		logic [LVL_BITS-1:0] lvl;
	} voice_smp_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] sample;
		logic                       active;
	} out_item_t;

	typedef logic signed [SAMPLE_BITS-1:0] sine_tab_t [SINE_DEPTH];

	function automatic logic [FREQ_BITS-1:0] top_oct_freq(logic [OCT_BITS-1:0] idx);
		logic [FREQ_BITS-1:0] f;
		case (idx)
			4'd0:    f = FREQ_BITS'(548668578);
			4'd1:    f = FREQ_BITS'(581294109);
			4'd2:    f = FREQ_BITS'(615859656);
			4'd3:    f = FREQ_BITS'(652480576);
			4'd4:    f = FREQ_BITS'(691279090);
			4'd5:    f = FREQ_BITS'(732384684);
			4'd6:    f = FREQ_BITS'(775934544);
			4'd7:    f = FREQ_BITS'(822074012);
			4'd8:    f = FREQ_BITS'(870957077);
			4'd9:    f = FREQ_BITS'(922746880);
			4'd10:   f = FREQ_BITS'(977616265);
			4'd11:   f = FREQ_BITS'(1035748353);
			default: f = '0;
		endcase
		return f;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(int unsigned k);
		logic [63:0] quad;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		logic signed [SAMPLE_BITS-1:0] mag;
		quad = 64'((k >> (SINE_ROM_BITS - 2)) & 3);
		r = 64'(k & (QUARTER - 1));
		if (quad[0]) begin
			r = 64'(QUARTER) - r;
		end
		x = (r * TWO_PI_Q30) >> SINE_ROM_BITS;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_D0;
		t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_D1;
		t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_D2;
		t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_D3;
		t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_D4;
		t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_D5;
		s = (x * t) >> 30;
		if (s > Q30_ONE) begin
			s = Q30_ONE;
		end
		v = (s * SINE_AMP + HALF_Q30) >> 30;
		mag = SAMPLE_BITS'(v);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
			tab[k] = sine_entry(k);
		end
		return tab;
	endfunction

endpackage

// ===== src/svae_front.sv =====
// Command front end: input register, note frequency and level target,
// phase step partial products. Depends on svae_pkg.
module svae_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_acc,
	input  logic [svae_pkg::CMD_BITS-1:0]  cmd,
	input  logic [svae_pkg::NOTE_BITS-1:0] note,
	input  logic [svae_pkg::CHAN_BITS-1:0] chan,
	input  logic [svae_pkg::VEL_BITS-1:0]  vel,
	input  logic [svae_pkg::INC_BITS-1:0]  inc_per_hz,
	output svae_pkg::note_cmd_t            cmd_s3
);
	import svae_pkg::*;

	logic                 valid_s1;
	cmd_e                 cmd_s1;
	logic [NOTE_BITS-1:0] note_s1;
	logic [CHAN_BITS-1:0] chan_s1;
	logic [VEL_BITS-1:0]  vel_s1;

	logic                 valid_s2;
	cmd_e                 cmd_s2;
	logic [NOTE_BITS-1:0] note_s2;
	logic [CHAN_BITS-1:0] chan_s2;
	logic [FREQ_BITS-1:0] freq_s2;
	logic [LVL_BITS-1:0]  tl_s2;

	logic [OCT_PROD-1:0]  oct_prod;
	logic [OCT_BITS-1:0]  oct;
	logic [NOTE_BITS-1:0] rem_full;
	logic [FREQ_BITS-1:0] freq;
	logic [LVL_BITS-1:0]  tl_raw;
	logic [LVL_BITS-1:0]  tl;

	always_comb begin
		oct_prod = OCT_PROD'(note_s1) * OCT_PROD'(OCT_RECIP);
		oct = oct_prod[OCT_SHIFT +: OCT_BITS];
		rem_full = note_s1 - NOTE_BITS'(NOTE_BITS'(oct) * NOTE_BITS'(NOTES_PER_OCT));
		freq = top_oct_freq(rem_full[OCT_BITS-1:0]) >> (OCT_BITS'(TOP_OCTAVE) - oct);
		tl_raw = LVL_BITS'(vel_s1) * LVL_BITS'(VEL_GAIN);
		tl = tl_raw;
		if (tl_raw < LVL_BITS'(LVL_MIN)) begin
			tl = LVL_BITS'(LVL_MIN);
		end
		if (tl_raw > LVL_BITS'(LVL_MAX)) begin
			tl = LVL_BITS'(LVL_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cmd_s3   <= '0;
		end else begin
			valid_s1     <= in_acc;
			valid_s2     <= valid_s1;
			cmd_s3.valid <= valid_s2;
			cmd_s3.cmd   <= cmd_s2;
			cmd_s3.note  <= note_s2;
			cmd_s3.chan  <= chan_s2;
			cmd_s3.tl    <= tl_s2;
			cmd_s3.p_lo  <= PP_BITS'(freq_s2) * PP_BITS'(inc_per_hz[INC_LO_BITS-1:0]);
			cmd_s3.p_hi  <= PP_BITS'(freq_s2) * PP_BITS'(inc_per_hz[INC_BITS-1:INC_LO_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= cmd_e'(cmd);
			note_s1 <= note;
			chan_s1 <= chan;
			vel_s1  <= vel;
		end
		cmd_s2  <= cmd_s1;
		note_s2 <= note_s1;
		chan_s2 <= chan_s1;
		freq_s2 <= freq;
		tl_s2   <= tl;
	end

endmodule

// ===== src/svae_voice.sv =====
// Voice state: phase accumulator, note latch and attack/release envelope.
// Takes one command per cycle from svae_front. Depends on svae_pkg.
module svae_voice (
	input  logic                              clk,
	input  logic                              arst_n,
	input  svae_pkg::note_cmd_t               cmd_s3,
	input  svae_pkg::cfg_t                    cfg,
	output svae_pkg::voice_smp_t              smp_s4,
	output logic [svae_pkg::SINE_ROM_BITS-1:0] rom_addr
);
	import svae_pkg::*;

	logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
	logic [PHASE_BITS-1:0] phase_step_q, phase_step_d;
	logic [NOTE_BITS-1:0]  held_note_q, held_note_d;
	logic [CHAN_BITS-1:0]  held_chan_q, held_chan_d;
	logic [LVL_BITS-1:0]   target_lvl_q, target_lvl_d;
	logic [LVL_BITS-1:0]   cur_lvl_q, cur_lvl_d;
	logic                  sounding_q, sounding_d;
	logic                  fading_q, fading_d;

	logic [PS_SUM_BITS-1:0] ps_sum;
	logic [PHASE_BITS-1:0]  step_new;
	logic [LVL_BITS:0]      up;
	logic [LVL_BITS-1:0]    rel_ext;
	voice_smp_t             smp_d;

	assign rom_addr = phase_acc_q[PHASE_BITS-1 -: SINE_ROM_BITS];

	always_comb begin
		ps_sum = {cmd_s3.p_hi, INC_LO_BITS'(0)} + PS_SUM_BITS'(cmd_s3.p_lo);
		step_new = ps_sum[PS_SHIFT +: PHASE_BITS];
		up = (LVL_BITS+1)'(cur_lvl_q) + (LVL_BITS+1)'(cfg.attack_step);
		rel_ext = LVL_BITS'(cfg.release_step);

		phase_acc_d  = phase_acc_q;
		phase_step_d = phase_step_q;
		held_note_d  = held_note_q;
		held_chan_d  = held_chan_q;
		target_lvl_d = target_lvl_q;
		cur_lvl_d    = cur_lvl_q;
		sounding_d   = sounding_q;
		fading_d     = fading_q;
		smp_d.valid  = 1'b0;
		smp_d.active = 1'b0;
		smp_d.lvl    = '0;

		if (cmd_s3.valid) begin
			case (cmd_s3.cmd)
				CMD_NOTE_ON: begin
					phase_step_d = step_new;
					target_lvl_d = cmd_s3.tl;
					held_note_d  = cmd_s3.note;
					held_chan_d  = cmd_s3.chan;
					phase_acc_d  = '0;
					cur_lvl_d    = '0;
					sounding_d   = 1'b1;
					fading_d     = 1'b0;
				end
				CMD_NOTE_OFF: begin
					if (sounding_q && held_note_q == cmd_s3.note
						&& held_chan_q == cmd_s3.chan) begin
						fading_d = 1'b1;
					end
				end
				CMD_TICK: begin
					smp_d.valid = 1'b1;
					if (sounding_q) begin
						if (fading_q && rel_ext >= cur_lvl_q) begin
							phase_acc_d  = '0;
							phase_step_d = '0;
							held_note_d  = '0;
							held_chan_d  = '0;
							target_lvl_d = '0;
							cur_lvl_d    = '0;
							sounding_d   = 1'b0;
							fading_d     = 1'b0;
						end else begin
							if (fading_q) begin
								cur_lvl_d = cur_lvl_q - rel_ext;
							end else if (cur_lvl_q < target_lvl_q) begin
								cur_lvl_d = (up < (LVL_BITS+1)'(target_lvl_q)) ?
									up[LVL_BITS-1:0] : target_lvl_q;
							end
							smp_d.active = 1'b1;
							smp_d.lvl    = cur_lvl_d;
							phase_acc_d  = phase_acc_q + phase_step_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q  <= '0;
			phase_step_q <= '0;
			held_note_q  <= '0;
			held_chan_q  <= '0;
			target_lvl_q <= '0;
			cur_lvl_q    <= '0;
			sounding_q   <= 1'b0;
			fading_q     <= 1'b0;
			smp_s4       <= '0;
		end else begin
			phase_acc_q  <= phase_acc_d;
			phase_step_q <= phase_step_d;
			held_note_q  <= held_note_d;
			held_chan_q  <= held_chan_d;
			target_lvl_q <= target_lvl_d;
			cur_lvl_q    <= cur_lvl_d;
			sounding_q   <= sounding_d;
			fading_q     <= fading_d;
			smp_s4       <= smp_d;
		end
	end

	a_fade_needs_sound: assert property (@(posedge clk) disable iff (!arst_n)
		fading_q |-> sounding_q)
		else $error("voice fading while not sounding");

	a_attack_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(sounding_q && !fading_q) |-> (cur_lvl_q <= target_lvl_q))
		else $error("attack level above target");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sounding_q |-> (cur_lvl_q == '0 && phase_acc_q == '0 && phase_step_q == '0))
		else $error("idle voice holds stale state");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_s4.valid && smp_s4.active) |-> $past(sounding_q))
		else $error("active sample from idle voice");

endmodule

// ===== src/svae_sine_rom.sv =====
// Full-wave sine table with registered read, built at elaboration.
// Depends on svae_pkg for the table function and widths.
module svae_sine_rom (
	input  logic                                    clk,
	input  logic [svae_pkg::SINE_ROM_BITS-1:0]       addr,
	output logic signed [svae_pkg::SAMPLE_BITS-1:0] data_s4
);
	import svae_pkg::*;

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	always_ff @(posedge clk) begin
		data_s4 <= SINE_TAB[addr];
	end

endmodule

// ===== src/svae_out.sv =====
// Sample scaling, saturation, output queue and input flow control.
// Depends on svae_pkg.
module svae_out (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  svae_pkg::voice_smp_t                    smp_s4,
	input  logic signed [svae_pkg::SAMPLE_BITS-1:0] sine_s4,
	input  logic                                    tick_acc,
	output logic                                    in_stall,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [svae_pkg::OUT_BITS-1:0]    sample,
	output logic                                    voice_active
);
	import svae_pkg::*;

	localparam logic signed [MUL_BITS-1:0] SMP_MAX = MUL_BITS'((1 << (OUT_BITS - 1)) - 1);
	localparam logic signed [MUL_BITS-1:0] SMP_MIN = MUL_BITS'(-(1 << (OUT_BITS - 1)));

	logic                       valid_s5;
	logic                       active_s5;
	logic signed [MUL_BITS-1:0] prod_s5;
	logic signed [MUL_BITS-1:0] lvl_x;
	logic signed [MUL_BITS-1:0] sine_x;
	logic signed [MUL_BITS-1:0] shr;
	logic signed [MUL_BITS-1:0] sat;
	out_item_t                  wr_item;

	out_item_t                  fifo_mem [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]   wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0]   rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0]   fifo_cnt_q;
	logic [FIFO_CNT_BITS-1:0]   cred_cnt_q;
	logic [FIFO_CNT_BITS-1:0]   cred_next;
	logic                       stall_q;
	logic                       out_acc;

	assign lvl_x  = $signed(MUL_BITS'(smp_s4.lvl));
	assign sine_x = MUL_BITS'(sine_s4);

	always_comb begin
		shr = prod_s5 >>> LVL_FRAC;
		sat = shr;
		if (shr > SMP_MAX) begin
			sat = SMP_MAX;
		end
		if (shr < SMP_MIN) begin
			sat = SMP_MIN;
		end
		wr_item.sample = OUT_BITS'(sat);
		wr_item.active = active_s5;
	end

	assign out_acc      = out_valid && !out_stall;
	assign out_valid    = fifo_cnt_q != '0;
	assign sample       = fifo_mem[rd_ptr_q].sample;
	assign voice_active = fifo_mem[rd_ptr_q].active;
	assign in_stall     = stall_q;
	assign cred_next    = cred_cnt_q + FIFO_CNT_BITS'(tick_acc) - FIFO_CNT_BITS'(out_acc);

	always_ff @(posedge clk) begin
		active_s5 <= smp_s4.active;
		prod_s5   <= lvl_x * sine_x;
		if (valid_s5) begin
			fifo_mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5   <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			cred_cnt_q <= '0;
			stall_q    <= 1'b0;
		end else begin
			valid_s5   <= smp_s4.valid;
			fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_BITS'(valid_s5) - FIFO_CNT_BITS'(out_acc);
			cred_cnt_q <= cred_next;
			stall_q    <= cred_next >= FIFO_CNT_BITS'(FIFO_DEPTH);
			if (valid_s5) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (fifo_cnt_q < FIFO_CNT_BITS'(FIFO_DEPTH) || out_acc))
		else $error("output queue written while full");

	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		cred_cnt_q >= fifo_cnt_q)
		else $error("queued samples exceed outstanding ticks");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cred_cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("outstanding ticks exceed queue depth");

endmodule

// ===== src/sine_voice_with_ar_envelope.sv =====
// Sine voice with linear attack/release envelope: top level and register port.
// Depends on svae_pkg, svae_front, svae_voice, svae_sine_rom and svae_out.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer:
//   tick, note on or note off, with note, chan and vel. Only a tick yields a
//   result on the output channel (out_valid/out_stall): sample and
//   voice_active. Note on, note off and unknown commands yield nothing.
//   Throughput: one command per cycle, any mix, while in_stall is low.
//   Results queue in an 8-entry output buffer; in_stall is registered and
//   rises once eight ticks are in flight or waiting, so a stalled receiver
//   stops the input after at most eight ticks and nothing is dropped.
//   Registers (APB, byte address 4*i): inc_per_hz, attack_step,
//   release_step. Write them only while the voice is idle.
//   Reset: voice silent with phase and level at zero, registers at their
//   defaults, output buffer empty, in_stall low.
module sine_voice_with_ar_envelope (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [svae_pkg::CMD_BITS-1:0]         cmd,
	input  logic [svae_pkg::NOTE_BITS-1:0]        note,
	input  logic [svae_pkg::CHAN_BITS-1:0]        chan,
	input  logic [svae_pkg::VEL_BITS-1:0]         vel,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [svae_pkg::OUT_BITS-1:0] sample,
	output logic                                 voice_active,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [svae_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [svae_pkg::DATA_BITS-1:0]        pwdata,
	output logic [svae_pkg::DATA_BITS-1:0]        prdata,
	output logic                                 pready
);
	import svae_pkg::*;

	cfg_t                      cfg_q;
	logic                      cfg_wr;
	reg_idx_e                  reg_idx;
	logic                      in_acc;
	logic                      tick_acc;
	note_cmd_t                 cmd_s3;
	voice_smp_t                smp_s4;
	logic [SINE_ROM_BITS-1:0]  rom_addr;
	logic signed [SAMPLE_BITS-1:0] sine_s4;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_idx  = reg_idx_e'(paddr[ADDR_BITS-1:2]);
	assign in_acc   = in_valid && !in_stall;
	assign tick_acc = in_acc && (cmd_e'(cmd) == CMD_TICK);

	always_comb begin
		case (reg_idx)
			REG_INC_PER_HZ:   prdata = DATA_BITS'(cfg_q.inc_per_hz);
			REG_ATTACK_STEP:  prdata = DATA_BITS'(cfg_q.attack_step);
			REG_RELEASE_STEP: prdata = DATA_BITS'(cfg_q.release_step);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inc_per_hz   <= INC_RESET;
			cfg_q.attack_step  <= ATTACK_RESET;
			cfg_q.release_step <= RELEASE_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INC_PER_HZ:   cfg_q.inc_per_hz   <= pwdata[INC_BITS-1:0];
				REG_ATTACK_STEP:  cfg_q.attack_step  <= pwdata[STEP_BITS-1:0];
				REG_RELEASE_STEP: cfg_q.release_step <= pwdata[STEP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	svae_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_acc     (in_acc),
		.cmd        (cmd),
		.note       (note),
		.chan       (chan),
		.vel        (vel),
		.inc_per_hz (cfg_q.inc_per_hz),
		.cmd_s3     (cmd_s3)
	);

	svae_voice u_voice (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_s3   (cmd_s3),
		.cfg      (cfg_q),
		.smp_s4   (smp_s4),
		.rom_addr (rom_addr)
	);

	svae_sine_rom u_rom (
		.clk     (clk),
		.addr    (rom_addr),
		.data_s4 (sine_s4)
	);

	svae_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp_s4       (smp_s4),
		.sine_s4      (sine_s4),
		.tick_acc     (tick_acc),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.voice_active (voice_active)
	);

endmodule

// ===== test/tb_sine_voice_with_ar_envelope.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sine_voice_with_ar_envelope: random note/tick traffic
// checked sample by sample against an in-bench voice model. Depends on svae_pkg and the RTL.
module tb_sine_voice_with_ar_envelope;
	import svae_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASE_ITEMS    = 70;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_PAUSE    = 12;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 100;

	typedef struct packed {
		logic [CMD_BITS-1:0]  cmd;
		logic [NOTE_BITS-1:0] note;
		logic [CHAN_BITS-1:0] chan;
		logic [VEL_BITS-1:0]  vel;
	} voice_cmd_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CMD_BITS-1:0]  cmd = '0;
	logic [NOTE_BITS-1:0] note = '0;
	logic [CHAN_BITS-1:0] chan = '0;
	logic [VEL_BITS-1:0]  vel = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [OUT_BITS-1:0] sample;
	logic                 voice_active;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	logic tx_gaps_on = 1'b0;
	logic rx_stall_on = 1'b0;
	logic hold_req = 1'b0;

	voice_cmd_t cmd_q[$];
	out_item_t  sample_q[$];
	int pending_cnt = 0;
	int err_cnt = 0;
	int accepted_cnt = 0;
	int ticks_sent = 0;
	int checked_cnt = 0;
	int settings_cnt = 0;

	logic signed [SAMPLE_BITS-1:0] sine_lut [SINE_DEPTH];
	logic [INC_BITS-1:0]  cfg_inc;
	logic [STEP_BITS-1:0] cfg_rise;
	logic [STEP_BITS-1:0] cfg_fall;
	logic [31:0] osc_phase;
	logic [31:0] osc_incr;
	logic [NOTE_BITS-1:0] key_note;
	logic [CHAN_BITS-1:0] key_chan;
	logic [31:0] env_goal;
	logic [31:0] env_lvl;
	logic is_on;
	logic is_releasing;

	sine_voice_with_ar_envelope uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .note(note), .chan(chan), .vel(vel),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample(sample), .voice_active(voice_active),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] semitone_q16(int unsigned i);
		case (i)
			0:       return 32'd548668578;
			1:       return 32'd581294109;
			2:       return 32'd615859656;
			3:       return 32'd652480576;
			4:       return 32'd691279090;
			5:       return 32'd732384684;
			6:       return 32'd775934544;
			7:       return 32'd822074012;
			8:       return 32'd870957077;
			9:       return 32'd922746880;
			10:      return 32'd977616265;
			default: return 32'd1035748353;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sine_point(int unsigned k);
		logic [63:0] r, x, x2, t, s, v;
		logic [1:0] quad;
		logic signed [SAMPLE_BITS-1:0] mag;
		quad = 2'(k >> (SINE_ROM_BITS - 2));
		r = 64'(k % QUARTER);
		if (quad[0]) begin
			r = 64'(QUARTER) - r;
		end
		x = (r * 64'd6746518852) >> SINE_ROM_BITS;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int m = 6; m >= 1; m--) begin
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(2 * m * (2 * m + 1));
		end
		s = (x * t) >> 30;
		if (s > (64'd1 << 30)) begin
			s = 64'd1 << 30;
		end
		v = (s * 64'((1 << (SAMPLE_BITS - 1)) - 1) + (64'd1 << 29)) >> 30;
		mag = SAMPLE_BITS'(v);
		return quad[1] ? -mag : mag;
	endfunction

	function automatic logic [31:0] reg_mask(reg_idx_e idx);
		return (idx == REG_INC_PER_HZ) ? 32'h0FFF_FFFF : 32'h000F_FFFF;
	endfunction

	task automatic voice_predict(input logic [CMD_BITS-1:0] c, input logic [NOTE_BITS-1:0] n,
			input logic [CHAN_BITS-1:0] ch, input logic [VEL_BITS-1:0] v);
		logic [63:0] freq;
		logic [31:0] goal;
		logic [31:0] rise;
		logic signed [63:0] amp;
		logic signed [63:0] prod;
		out_item_t res;
		int oct;
		res = '0;
		if (c == CMD_NOTE_ON) begin
			oct = int'(n) / 12;
			freq = 64'(semitone_q16(int'(n) % 12)) >> (10 - oct);
			osc_incr = 32'((freq * 64'(cfg_inc)) >> 24);
			goal = 32'(v) * VEL_GAIN;
			if (goal < LVL_MIN) begin
				goal = LVL_MIN;
			end else if (goal > LVL_MAX) begin
				goal = LVL_MAX;
			end
			env_goal = goal;
			key_note = n;
			key_chan = ch;
			osc_phase = '0;
			env_lvl = '0;
			is_on = 1'b1;
			is_releasing = 1'b0;
		end else if (c == CMD_NOTE_OFF) begin
			if (is_on && key_note == n && key_chan == ch) begin
				is_releasing = 1'b1;
			end
		end else if (c == CMD_TICK) begin
			ticks_sent++;
			if (is_on && is_releasing && cfg_fall >= env_lvl) begin
				osc_phase = '0;
				osc_incr = '0;
				key_note = '0;
				key_chan = '0;
				env_goal = '0;
				env_lvl = '0;
				is_on = 1'b0;
				is_releasing = 1'b0;
			end else if (is_on) begin
				if (is_releasing) begin
					env_lvl = env_lvl - cfg_fall;
				end else if (env_lvl < env_goal) begin
					rise = env_lvl + cfg_rise;
					env_lvl = (rise < env_goal) ? rise : env_goal;
				end
				amp = sine_lut[osc_phase[31 -: SINE_ROM_BITS]];
				prod = amp * $signed({32'd0, env_lvl});
				prod = prod >>> 24;
				if (prod > 32767) begin
					prod = 32767;
				end else if (prod < -32768) begin
					prod = -32768;
				end
				res.sample = prod[OUT_BITS-1:0];
				res.active = 1'b1;
				osc_phase = osc_phase + osc_incr;
			end
			sample_q.push_back(res);
		end
	endtask

	// sender: bursts of random length, random gaps between them when tx_gaps_on is set
	always @(posedge clk or negedge arst_n) begin : sender
		voice_cmd_t nxt;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= '0;
			note <= '0;
			chan <= '0;
			vel <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				voice_predict(cmd, note, chan, vel);
				accepted_cnt++;
				pending_cnt--;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gaps_on && gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					nxt = cmd_q.pop_front();
					cmd <= nxt.cmd;
					note <= nxt.note;
					chan <= nxt.chan;
					vel <= nxt.vel;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = $urandom_range(0, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: alternating stall and pass runs when rx_stall_on is set, plus one long hold on request
	always @(posedge clk or negedge arst_n) begin : receiver
		int hold_left;
		int run_left;
		logic hold_used;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			run_left = 0;
			hold_used = 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_used = 1'b1;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (run_left != 0) begin
			run_left--;
		end else begin
			out_stall <= rx_stall_on && !out_stall;
			run_left = out_stall ? $urandom_range(0, 10) : $urandom_range(0, 5);
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			checked_cnt++;
			if (sample_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: unexpected result sample=%0d voice_active=%0b",
						$time, sample, voice_active);
			end else begin
				want = sample_q.pop_front();
				if (sample !== want.sample) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: sample expected %0d actual %0d",
							$time, want.sample, sample);
				end
				if (voice_active !== want.active) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: voice_active expected %0b actual %0b",
							$time, want.active, voice_active);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic program_reg(reg_idx_e idx, logic [31:0] val);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== (val & reg_mask(idx))) begin
			err_cnt++;
			$display("%0t: readback of register %s expected 0x%08h actual 0x%08h",
				$time, idx.name(), val & reg_mask(idx), got);
		end
		case (idx)
			REG_INC_PER_HZ:  cfg_inc = val[INC_BITS-1:0];
			REG_ATTACK_STEP: cfg_rise = val[STEP_BITS-1:0];
			default:         cfg_fall = val[STEP_BITS-1:0];
		endcase
	endtask

	task automatic push_cmd(logic [CMD_BITS-1:0] c, logic [NOTE_BITS-1:0] n,
			logic [CHAN_BITS-1:0] ch, logic [VEL_BITS-1:0] v, inout int made);
		voice_cmd_t it;
		it.cmd = c;
		it.note = n;
		it.chan = ch;
		it.vel = v;
		cmd_q.push_back(it);
		pending_cnt++;
		if (c != CMD_UNUSED) begin
			made++;
		end
	endtask

	task automatic push_tick_or_noise(inout int made);
		if ($urandom_range(0, 11) == 0) begin
			push_cmd(CMD_BITS'($urandom_range(0, 3)), NOTE_BITS'($urandom),
				CHAN_BITS'($urandom), VEL_BITS'($urandom), made);
		end else begin
			push_cmd(CMD_TICK, NOTE_BITS'($urandom), CHAN_BITS'($urandom),
				VEL_BITS'($urandom), made);
		end
	endtask

	task automatic push_voice_sequence(inout int made);
		logic [NOTE_BITS-1:0] n;
		logic [CHAN_BITS-1:0] ch;
		n = NOTE_BITS'($urandom);
		ch = CHAN_BITS'($urandom);
		push_cmd(CMD_NOTE_ON, n, ch, VEL_BITS'($urandom), made);
		repeat ($urandom_range(0, 40)) push_tick_or_noise(made);
		case ($urandom_range(0, 5))
			0: push_cmd(CMD_NOTE_OFF, n ^ NOTE_BITS'($urandom_range(1, 127)), ch,
				VEL_BITS'($urandom), made);
			1: push_cmd(CMD_NOTE_OFF, n, ch ^ CHAN_BITS'($urandom_range(1, 31)),
				VEL_BITS'($urandom), made);
			default: push_cmd(CMD_NOTE_OFF, n, ch, VEL_BITS'($urandom), made);
		endcase
		repeat ($urandom_range(0, 70)) push_tick_or_noise(made);
	endtask

	task automatic wait_drained();
		while (pending_cnt != 0 || sample_q.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// release the held note and tick until the level runs out
	task automatic silence_voice();
		int made;
		int n;
		while (is_on) begin
			@(negedge clk);
			made = 0;
			push_cmd(CMD_NOTE_OFF, key_note, key_chan, '0, made);
			n = (cfg_fall == 0) ? 1 : int'(env_lvl / cfg_fall) + 2;
			repeat (n) push_cmd(CMD_TICK, '0, '0, '0, made);
			wait_drained();
		end
	endtask

	task automatic run_phase(logic [31:0] inc, logic [31:0] rise, logic [31:0] fall,
			logic gaps, logic stalls, logic long_hold);
		int made;
		program_reg(REG_INC_PER_HZ, inc);
		program_reg(REG_ATTACK_STEP, rise);
		program_reg(REG_RELEASE_STEP, fall);
		settings_cnt++;
		tx_gaps_on <= gaps;
		rx_stall_on <= stalls;
		if (long_hold) begin
			hold_req <= 1'b1;
		end
		@(negedge clk);
		made = 0;
		while (made < PHASE_ITEMS) push_voice_sequence(made);
		wait_drained();
		silence_voice();
	endtask

	initial begin : stimulus
		int made;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			sine_lut[k] = sine_point(k);
		end
		cfg_inc = INC_RESET;
		cfg_rise = ATTACK_RESET;
		cfg_fall = RELEASE_RESET;
		osc_phase = '0;
		osc_incr = '0;
		key_note = '0;
		key_chan = '0;
		env_goal = '0;
		env_lvl = '0;
		is_on = 1'b0;
		is_releasing = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		program_reg(REG_INC_PER_HZ, 32'(INC_RESET));
		program_reg(REG_ATTACK_STEP, 32'(ATTACK_RESET));
		program_reg(REG_RELEASE_STEP, 32'(RELEASE_RESET));
		settings_cnt++;

		@(negedge clk);
		made = 0;
		push_cmd(CMD_TICK, '0, '0, '0, made);
		push_cmd(CMD_NOTE_OFF, 7'd0, 5'd1, '0, made);
		push_cmd(CMD_UNUSED, '0, '0, '0, made);
		push_cmd(CMD_NOTE_ON, 7'd0, 5'd1, 7'd0, made);
		push_cmd(CMD_TICK, '0, '0, '0, made);
		push_cmd(CMD_TICK, '1, '1, '1, made);
		push_cmd(CMD_NOTE_OFF, 7'd0, 5'd2, '0, made);
		push_cmd(CMD_NOTE_OFF, 7'd1, 5'd1, '0, made);
		push_cmd(CMD_TICK, '0, '0, '0, made);
		push_cmd(CMD_NOTE_ON, 7'd127, 5'd16, 7'd127, made);
		repeat (3) push_cmd(CMD_TICK, '0, '0, '0, made);
		push_cmd(CMD_NOTE_ON, 7'd69, 5'd31, 7'd64, made);
		push_cmd(CMD_TICK, '0, '0, '0, made);
		push_cmd(CMD_NOTE_OFF, 7'd69, 5'd31, '1, made);
		push_cmd(CMD_TICK, '0, '0, '0, made);
		push_cmd(CMD_NOTE_OFF, 7'd69, 5'd31, '0, made);
		push_cmd(CMD_UNUSED, '1, '1, '1, made);
		repeat (2) push_cmd(CMD_TICK, '0, '0, '0, made);
		wait_drained();
		silence_voice();

		run_phase(32'h0FFF_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 1'b0, 1'b0, 1'b0);
		run_phase(32'd1, 32'd1, 32'd1, 1'b1, 1'b1, 1'b0);
		run_phase(32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);
		run_phase(32'(INC_RESET), 32'(ATTACK_RESET), 32'(RELEASE_RESET), 1'b1, 1'b0, 1'b1);
		run_phase({4'hF, 28'($urandom_range(1, 28'h0FF_FFFF))},
			{12'hFFF, 20'($urandom_range(1000, 300000))},
			{12'hA5C, 20'($urandom_range(1000, 200000))}, 1'b1, 1'b1, 1'b0);
		repeat (5) begin
			run_phase($urandom_range(1, 28'hFFF_FFFF), $urandom_range(1000, 400000),
				$urandom_range(1000, 200000), 1'($urandom), 1'($urandom), 1'b0);
		end

		wait_drained();
		if (sample_q.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d expected results never arrived", $time, sample_q.size());
		end
		$display("covered %0d commands (%0d ticks), %0d samples compared", accepted_cnt,
			ticks_sent, checked_cnt);
		$display("over %0d register settings incl. extremes, zero steps and a long output hold",
			settings_cnt);
		if (err_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
